@@ rtl/core/cpd_pkg.sv @@
package cpd_pkg;

	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int MAX_SIDE_DEF      = 8;
	localparam int COUNT_BITS_DEF    = 32;

	localparam int PATTERN_W = 64;
	localparam int SIDE_W    = 4;
	localparam int EXTENT_W  = 2 * SIDE_W;
	localparam int INDEX_W   = 8;
	localparam int COUNT_W   = 32;
	localparam int USED_W    = 9;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_READ   = 1'b1;

	typedef struct packed {
		logic                 operation;
		logic [PATTERN_W-1:0] pattern_bits;
		logic [SIDE_W-1:0]    pattern_rows;
		logic [SIDE_W-1:0]    pattern_cols;
		logic [INDEX_W-1:0]   read_index;
	} in_item_t;

	typedef struct packed {
		logic [INDEX_W-1:0]   entry_index;
		logic                 is_new;
		logic                 table_full;
		logic                 entry_valid;
		logic [COUNT_W-1:0]   entry_count;
		logic [PATTERN_W-1:0] entry_pattern;
		logic [SIDE_W-1:0]    entry_rows;
		logic [SIDE_W-1:0]    entry_cols;
		logic [USED_W-1:0]    entries_used;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_HIT,
		ST_MISS,
		ST_READ
	} cpd_state_t;

	typedef struct packed {
		logic load;
		logic scan_issue;
		logic read_issue;
		logic commit_hit;
		logic commit_insert;
		logic commit_full;
		logic commit_read;
	} cpd_cmd_t;

	typedef struct packed {
		logic op_read;
		logic hit;
		logic scan_more;
		logic room;
		logic out_busy;
	} cpd_stat_t;

endpackage

@@ rtl/core/cpd_ram.sv @@
module cpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/core/cpd_ctrl.sv @@
module cpd_ctrl
	import cpd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  cpd_stat_t stat,
	output cpd_cmd_t  cmd
);

	cpd_state_t state_q;
	cpd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_START;
			end
			ST_START: begin
				state_d = stat.op_read ? ST_READ : ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.hit) state_d = ST_HIT;
				else if (!stat.scan_more) state_d = ST_MISS;
			end
			ST_HIT, ST_MISS, ST_READ: begin
				if (!stat.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.load   = item_valid;
			end
			ST_START: begin
				cmd.read_issue = stat.op_read;
			end
			ST_SCAN: begin
				cmd.scan_issue = !stat.hit && stat.scan_more;
			end
			ST_HIT: begin
				cmd.commit_hit = !stat.out_busy;
			end
			ST_MISS: begin
				cmd.commit_insert = !stat.out_busy && stat.room;
				cmd.commit_full   = !stat.out_busy && !stat.room;
			end
			ST_READ: begin
				cmd.commit_read = !stat.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/core/cpd_datapath.sv @@
module cpd_datapath
	import cpd_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int MAX_SIDE      = MAX_SIDE_DEF,
	parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  item,
	output out_item_t result,
	output logic      result_valid,
	input  logic      result_ready,
	input  cpd_cmd_t  cmd,
	output cpd_stat_t stat
);

	localparam int IW   = $clog2(TABLE_ENTRIES);
	localparam int UW   = $clog2(TABLE_ENTRIES + 1);
	localparam int CMPW = (UW > INDEX_W) ? UW : INDEX_W;
	localparam int EW   = PATTERN_W + EXTENT_W + COUNT_BITS;

	// item registers
	logic                 op_q;
	logic [PATTERN_W-1:0] bits_q;
	logic [EXTENT_W-1:0]  ext_q;
	logic [INDEX_W-1:0]   ri_q;

	logic [UW-1:0] used_q;
	logic [UW-1:0] scan_q;
	logic          rd_v_s1;
	logic [IW-1:0] rd_idx_s1;

	out_item_t out_q;
	logic      out_valid_q;

	logic [SIDE_W-1:0]    rows_c;
	logic [SIDE_W-1:0]    cols_c;
	logic [7:0]           nbits;
	logic [PATTERN_W-1:0] mask;

	logic                  ram_we;
	logic [IW-1:0]         ram_waddr;
	logic [EW-1:0]         ram_wdata;
	logic                  ram_re;
	logic [IW-1:0]         ram_raddr;
	logic [EW-1:0]         ram_rdata;

	logic [PATTERN_W-1:0]  st_pattern;
	logic [EXTENT_W-1:0]   st_ext;
	logic [COUNT_BITS-1:0] st_count;
	logic [COUNT_BITS-1:0] inc_count;
	logic                  match;
	logic                  ri_in_range;

	always_comb begin
		rows_c = (item.pattern_rows > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : item.pattern_rows;
		cols_c = (item.pattern_cols > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : item.pattern_cols;
		nbits  = 8'(rows_c) * 8'(cols_c);
		mask   = (nbits >= 8'(PATTERN_W)) ? '1 : ((PATTERN_W'(1) << nbits) - PATTERN_W'(1));
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= item.operation;
			bits_q <= item.pattern_bits & mask;
			ext_q  <= {rows_c, cols_c};
			ri_q   <= item.read_index;
		end
		if (cmd.scan_issue) begin
			rd_idx_s1 <= scan_q[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			scan_q  <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.scan_issue;
			if (cmd.load) begin
				scan_q <= '0;
			end else if (cmd.scan_issue) begin
				scan_q <= scan_q + UW'(1);
			end
			if (cmd.commit_insert) begin
				used_q <= used_q + UW'(1);
			end
		end
	end

	assign st_pattern = ram_rdata[EW-1 -: PATTERN_W];
	assign st_ext     = ram_rdata[COUNT_BITS +: EXTENT_W];
	assign st_count   = ram_rdata[COUNT_BITS-1:0];
	assign inc_count  = (&st_count) ? st_count : st_count + COUNT_BITS'(1);
	assign match      = (st_ext == ext_q) && (st_pattern == bits_q);
	assign ri_in_range = CMPW'(ri_q) < CMPW'(used_q);

	always_comb begin
		ram_re    = cmd.scan_issue || cmd.read_issue;
		ram_raddr = cmd.read_issue ? IW'(ri_q) : scan_q[IW-1:0];
		ram_we    = cmd.commit_hit || cmd.commit_insert;
		if (cmd.commit_hit) begin
			ram_waddr = rd_idx_s1;
			ram_wdata = {st_pattern, st_ext, inc_count};
		end else begin
			ram_waddr = IW'(used_q);
			ram_wdata = {bits_q, ext_q, COUNT_BITS'(1)};
		end
	end

	cpd_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.commit_hit) begin
			out_q              <= '0;
			out_q.entry_index  <= INDEX_W'(rd_idx_s1);
			out_q.entry_count  <= COUNT_W'(inc_count);
			out_q.entries_used <= USED_W'(used_q);
		end else if (cmd.commit_insert) begin
			out_q              <= '0;
			out_q.entry_index  <= INDEX_W'(used_q);
			out_q.is_new       <= 1'b1;
			out_q.entry_count  <= COUNT_W'(1);
			out_q.entries_used <= USED_W'(used_q + UW'(1));
		end else if (cmd.commit_full) begin
			out_q              <= '0;
			out_q.table_full   <= 1'b1;
			out_q.entries_used <= USED_W'(used_q);
		end else if (cmd.commit_read) begin
			out_q              <= '0;
			out_q.entry_index  <= ri_q;
			out_q.entries_used <= USED_W'(used_q);
			if (ri_in_range) begin
				out_q.entry_valid   <= 1'b1;
				out_q.entry_count   <= COUNT_W'(st_count);
				out_q.entry_pattern <= st_pattern;
				out_q.entry_rows    <= st_ext[EXTENT_W-1 -: SIDE_W];
				out_q.entry_cols    <= st_ext[SIDE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit_hit || cmd.commit_insert || cmd.commit_full || cmd.commit_read) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result       = out_q;
	assign result_valid = out_valid_q;

	always_comb begin
		stat.op_read   = (op_q == OP_READ);
		stat.hit       = rd_v_s1 && match;
		stat.scan_more = scan_q < used_q;
		stat.room      = used_q < UW'(TABLE_ENTRIES);
		stat.out_busy  = out_valid_q && !result_ready;
	end

`ifndef ASSERT_OFF
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(TABLE_ENTRIES))
		else $error("entry count beyond table size");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_insert |-> stat.room)
		else $error("insert into full table");

	a_one_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.commit_hit, cmd.commit_insert, cmd.commit_full, cmd.commit_read}))
		else $error("more than one commit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit_hit || cmd.commit_insert || cmd.commit_full || cmd.commit_read)
		|-> !(out_valid_q && !result_ready))
		else $error("result register overwritten");

	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("table read and write in one cycle");
`endif

endmodule

@@ rtl/core/cluster_pattern_dictionary_core.sv @@
// Cluster pattern dictionary: stores up to TABLE_ENTRIES distinct cluster bitmaps with
// their extents and a saturating occurrence count in one table memory with separate
// read and write ports. A record item scans the stored entries in insertion order, one
// table read per cycle, and then bumps the matching count, appends a new entry, or
// reports that the table is full. One item is handled at a time; a finished result
// waits in an output register while the next item is accepted. Rows and columns above
// MAX_SIDE are clamped, and bitmap bits beyond rows*cols are ignored and stored as zero.
module cluster_pattern_dictionary_core
	import cpd_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int MAX_SIDE      = MAX_SIDE_DEF,
	parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	cpd_cmd_t  cmd;
	cpd_stat_t stat;

	cpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cpd_datapath #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.MAX_SIDE     (MAX_SIDE),
		.COUNT_BITS   (COUNT_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.result      (result),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule

@@ test/tb.sv @@
module tb;
	import cpd_pkg::*;

	localparam int TABLE_DEPTH = TABLE_ENTRIES_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	in_item_t  item = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_item_t result;

	cluster_pattern_dictionary_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// dictionary copy kept by the testbench
	logic [PATTERN_W-1:0] dict_pattern [TABLE_DEPTH];
	logic [SIDE_W-1:0]    dict_rows [TABLE_DEPTH];
	logic [SIDE_W-1:0]    dict_cols [TABLE_DEPTH];
	logic [COUNT_W-1:0]   dict_count [TABLE_DEPTH];
	int                   dict_used = 0;

	out_item_t dict_replies[$];
	out_item_t reply_head;
	int        mismatches = 0;
	int        stall_cycles = 0;
	bit        send_idle = 1'b1;
	bit        take_stall = 1'b1;

	function automatic logic [SIDE_W-1:0] clamp_side(logic [SIDE_W-1:0] side);
		return (side > MAX_SIDE_DEF) ? SIDE_W'(MAX_SIDE_DEF) : side;
	endfunction

	function automatic logic [PATTERN_W-1:0] footprint_mask(logic [SIDE_W-1:0] r,
		logic [SIDE_W-1:0] c);
		int n;
		n = int'(r) * int'(c);
		if (n >= PATTERN_W)
			return '1;
		return (64'd1 << n) - 64'd1;
	endfunction

	function automatic int find_entry(logic [SIDE_W-1:0] r, logic [SIDE_W-1:0] c,
		logic [PATTERN_W-1:0] bits);
		for (int i = 0; i < dict_used; i++)
			if (dict_rows[i] == r && dict_cols[i] == c && dict_pattern[i] == bits)
				return i;
		return -1;
	endfunction

	function automatic logic [PATTERN_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic dictionary_lookup(input in_item_t it, output out_item_t res);
		logic [SIDE_W-1:0]    r;
		logic [SIDE_W-1:0]    c;
		logic [PATTERN_W-1:0] bits;
		int                   hit;
		res = '0;
		if (it.operation == OP_RECORD) begin
			r = clamp_side(it.pattern_rows);
			c = clamp_side(it.pattern_cols);
			bits = it.pattern_bits & footprint_mask(r, c);
			hit = find_entry(r, c, bits);
			if (hit >= 0) begin
				if (dict_count[hit] != '1)
					dict_count[hit] = dict_count[hit] + 1'b1;
				res.entry_index = INDEX_W'(hit);
				res.entry_count = dict_count[hit];
			end else if (dict_used < TABLE_DEPTH) begin
				dict_pattern[dict_used] = bits;
				dict_rows[dict_used] = r;
				dict_cols[dict_used] = c;
				dict_count[dict_used] = 1;
				res.entry_index = INDEX_W'(dict_used);
				res.entry_count = 1;
				res.is_new = 1'b1;
				dict_used++;
			end else begin
				res.table_full = 1'b1;
			end
		end else begin
			res.entry_index = it.read_index;
			if (it.read_index < dict_used) begin
				res.entry_valid = 1'b1;
				res.entry_count = dict_count[it.read_index];
				res.entry_pattern = dict_pattern[it.read_index];
				res.entry_rows = dict_rows[it.read_index];
				res.entry_cols = dict_cols[it.read_index];
			end
		end
		res.entries_used = USED_W'(dict_used);
	endtask

	// called right after a rising edge; valid stays high into the next item unless an idle gap is inserted
	task automatic send_item(input in_item_t it);
		out_item_t res;
		while (send_idle && $urandom_range(99) < 8) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		dictionary_lookup(it, res);
		dict_replies.push_back(res);
	endtask

	function automatic in_item_t make_record(logic [SIDE_W-1:0] r, logic [SIDE_W-1:0] c,
		logic [PATTERN_W-1:0] bits);
		in_item_t it;
		it.operation = OP_RECORD;
		it.pattern_bits = bits;
		it.pattern_rows = r;
		it.pattern_cols = c;
		it.read_index = INDEX_W'($urandom);
		return it;
	endfunction

	function automatic in_item_t make_read(logic [INDEX_W-1:0] idx);
		in_item_t it;
		it.operation = OP_READ;
		it.pattern_bits = rand64();
		it.pattern_rows = SIDE_W'($urandom);
		it.pattern_cols = SIDE_W'($urandom);
		it.read_index = idx;
		return it;
	endfunction

	function automatic logic [SIDE_W-1:0] pick_side();
		int roll;
		roll = $urandom_range(99);
		if (roll < 6)
			return '0;
		if (roll < 12)
			return SIDE_W'($urandom_range(15, MAX_SIDE_DEF + 1));
		if (roll < 50)
			return SIDE_W'($urandom_range(3, 1));
		return SIDE_W'($urandom_range(MAX_SIDE_DEF, 1));
	endfunction

	// repeat of a stored entry (junk above the footprint, unclamped sides) or a fresh one
	function automatic in_item_t random_record(int repeat_pct);
		int                   i;
		logic [SIDE_W-1:0]    r;
		logic [SIDE_W-1:0]    c;
		if (dict_used > 0 && $urandom_range(99) < repeat_pct) begin
			i = $urandom_range(dict_used - 1);
			r = dict_rows[i];
			c = dict_cols[i];
			if (r == MAX_SIDE_DEF && $urandom_range(1))
				r = SIDE_W'($urandom_range(15, MAX_SIDE_DEF));
			if (c == MAX_SIDE_DEF && $urandom_range(1))
				c = SIDE_W'($urandom_range(15, MAX_SIDE_DEF));
			return make_record(r, c,
				dict_pattern[i] | (rand64() & ~footprint_mask(dict_rows[i], dict_cols[i])));
		end
		return make_record(pick_side(), pick_side(), rand64());
	endfunction

	function automatic in_item_t random_read();
		if (dict_used > 0 && $urandom_range(99) < 85)
			return make_read(INDEX_W'($urandom_range(dict_used - 1)));
		return make_read(INDEX_W'($urandom));
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] exp_val,
		input logic [63:0] act_val);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %h, got %h", what, exp_val, act_val);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (dict_replies.size() == 0) begin
					note_mismatch("unexpected result", '0, 64'(result.entry_index));
				end else begin
					reply_head = dict_replies.pop_front();
					if (result.entry_index !== reply_head.entry_index)
						note_mismatch("entry_index", 64'(reply_head.entry_index),
							64'(result.entry_index));
					if (result.is_new !== reply_head.is_new)
						note_mismatch("is_new", 64'(reply_head.is_new), 64'(result.is_new));
					if (result.table_full !== reply_head.table_full)
						note_mismatch("table_full", 64'(reply_head.table_full),
							64'(result.table_full));
					if (result.entry_valid !== reply_head.entry_valid)
						note_mismatch("entry_valid", 64'(reply_head.entry_valid),
							64'(result.entry_valid));
					if (result.entry_count !== reply_head.entry_count)
						note_mismatch("entry_count", 64'(reply_head.entry_count),
							64'(result.entry_count));
					if (result.entry_pattern !== reply_head.entry_pattern)
						note_mismatch("entry_pattern", reply_head.entry_pattern,
							result.entry_pattern);
					if (result.entry_rows !== reply_head.entry_rows)
						note_mismatch("entry_rows", 64'(reply_head.entry_rows),
							64'(result.entry_rows));
					if (result.entry_cols !== reply_head.entry_cols)
						note_mismatch("entry_cols", 64'(reply_head.entry_cols),
							64'(result.entry_cols));
					if (result.entries_used !== reply_head.entries_used)
						note_mismatch("entries_used", 64'(reply_head.entries_used),
							64'(result.entries_used));
				end
			end
			result_ready <= take_stall ? ($urandom_range(99) >= 8) : 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic test_directed();
		send_item(make_read(8'h00));
		send_item(make_record(4'd1, 4'd1, '1));
		send_item(make_record(4'd1, 4'd1, 64'd1));
		send_item(make_record(4'd8, 4'd8, '1));
		send_item(make_record(4'd8, 4'd8, '0));
		send_item(make_record(4'd15, 4'd12, '1));
		send_item(make_record(4'd0, 4'd5, rand64()));
		send_item(make_record(4'd0, 4'd5, rand64()));
		send_item(make_record(4'd0, 4'd0, rand64()));
		send_item(make_record(4'd5, 4'd0, rand64()));
		send_item(make_record(4'd2, 4'd3, 64'hffff_ffff_ffff_ffc0));
		send_item(make_record(4'd3, 4'd2, '0));
		send_item(make_record(4'd8, 4'd8, 64'haaaa_aaaa_aaaa_aaaa));
		send_item(make_record(4'd9, 4'd9, 64'h5555_5555_5555_5555));
		send_item(make_record(4'd8, 4'd15, 64'haaaa_aaaa_aaaa_aaaa));
		send_item(make_record(4'd7, 4'd4, 64'h0123_4567_89ab_cdef));
		send_item(make_read(8'h00));
		send_item(make_read(8'h02));
		send_item(make_read(INDEX_W'(dict_used - 1)));
		send_item(make_read(INDEX_W'(dict_used)));
		send_item(make_read(8'hff));
		send_item(make_read(8'haa));
	endtask

	task automatic test_random_mix(input int n);
		for (int k = 0; k < n; k++) begin
			send_idle = (k >= 120);
			take_stall = (k >= 120);
			if ($urandom_range(99) < 20)
				send_item(random_read());
			else
				send_item(random_record(55));
		end
	endtask

	task automatic test_fill_table();
		logic [SIDE_W-1:0]    r;
		logic [SIDE_W-1:0]    c;
		logic [PATTERN_W-1:0] bits;
		while (dict_used < TABLE_DEPTH) begin
			do begin
				r = SIDE_W'($urandom_range(MAX_SIDE_DEF, 1));
				c = SIDE_W'($urandom_range(MAX_SIDE_DEF, 1));
				bits = rand64();
			end while (find_entry(r, c, bits & footprint_mask(r, c)) >= 0);
			send_item(make_record(r, c, bits));
		end
		send_item(make_record(4'd8, 4'd8, rand64()));
		send_item(make_read(8'hff));
		send_item(make_record(dict_rows[TABLE_DEPTH-1], dict_cols[TABLE_DEPTH-1],
			dict_pattern[TABLE_DEPTH-1]));
	endtask

	task automatic test_full_table(input int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 30)
				send_item(random_read());
			else
				send_item(random_record(70));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(260);
		test_fill_table();
		test_full_table(160);
		item_valid <= 1'b0;
		while (dict_replies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
